### hw/rtl/gyro_cadence_rpm_filter_top_macros.svh
// assertion helpers for the top-level rtl file
// every use is clocked on i_clk and held off while i_rst_n is low
`ifndef GYRO_CADENCE_RPM_FILTER_TOP_MACROS_SVH
`define GYRO_CADENCE_RPM_FILTER_TOP_MACROS_SVH

// same-cycle implication
`define GCRF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gcrf assertion failed");

// next-cycle implication
`define GCRF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gcrf assertion failed");

`endif

### hw/rtl/gcrf_pkg.sv
package gcrf_pkg;

    // field widths
    localparam int RAW_W    = 16;
    localparam int TIME_W   = 32;
    localparam int RPM_W    = 16;
    localparam int FILT_W   = 24;
    localparam int CFG_W    = 16;
    localparam int CFG_AW   = 3;
    localparam int IN_DW    = 3 * RAW_W + TIME_W;

    // shared multiply-accumulate unit
    localparam int MAC_W    = 17;
    localparam int PROD_W   = 2 * MAC_W;
    localparam int ACC_W    = 41;
    localparam int ROUND_HALF = 32768;

    // square root unit
    localparam int RAD_W      = 32;
    localparam int ROOT_W     = 16;
    localparam int REM_W      = ROOT_W + 1;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int STEP_W     = $clog2(SQRT_STEPS);

    // register indexes
    localparam logic [CFG_AW-1:0] CFG_READY   = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_SCALE   = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_MIN     = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_ALPHA   = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_TIMEOUT = 3'd4;

    // register reset values
    localparam logic [CFG_W-1:0] RST_SCALE   = 16'd24467;
    localparam logic [CFG_W-1:0] RST_MIN     = 16'd1280;
    localparam logic [CFG_W-1:0] RST_ALPHA   = 16'd6554;
    localparam logic [CFG_W-1:0] RST_TIMEOUT = 16'd250;

    typedef enum logic [1:0] {
        ST_FRESH = 2'd0,
        ST_HELD  = 2'd1,
        ST_STALE = 2'd2,
        ST_OFF   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        K_SAMPLE,
        K_FAIL,
        K_OFF
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_ROOT,
        S_SCALE,
        S_BLEND,
        S_FINISH
    } t_state;

    // one issue to the multiply-accumulate unit
    typedef struct packed {
        logic en;
        logic clr;
        logic rnd;
        logic shl8;
    } t_mac_ctl;

    // square root unit status
    typedef struct packed {
        logic busy;
        logic done;
    } t_sqrt_stat;

    // magnitude of a two's complement count, full negative range included
    function automatic logic [MAC_W-1:0] abs17(input logic [RAW_W-1:0] v);
        logic [MAC_W-1:0] e;
        e = {v[RAW_W-1], v};
        return v[RAW_W-1] ? MAC_W'(~e + MAC_W'(1)) : e;
    endfunction

endpackage

### hw/rtl/gcrf_mac.sv
module gcrf_mac (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  gcrf_pkg::t_mac_ctl        i_ctl,
    input  logic [gcrf_pkg::MAC_W-1:0] i_a,
    input  logic [gcrf_pkg::MAC_W-1:0] i_b,
    output logic [gcrf_pkg::ACC_W-1:0] o_acc
);
    import gcrf_pkg::*;

    t_mac_ctl           r_ctl;
    logic [PROD_W-1:0]  r_prod;
    logic [ACC_W-1:0]   r_acc;
    logic [ACC_W-1:0]   n_acc;
    logic [ACC_W-1:0]   addend;
    logic [ACC_W-1:0]   base;

    // product stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
        end
    end

    // accumulate stage
    always_comb begin
        addend = r_ctl.shl8 ? ACC_W'({r_prod, 8'b0}) : ACC_W'(r_prod);
        if (r_ctl.clr) begin
            base = r_ctl.rnd ? ACC_W'(ROUND_HALF) : '0;
        end else begin
            base = r_acc;
        end
        n_acc = base + addend;
    end

    always_ff @(posedge i_clk) begin
        if (r_ctl.en) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

### hw/rtl/gcrf_isqrt.sv
module gcrf_isqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [gcrf_pkg::RAD_W-1:0]  i_rad,
    output logic [gcrf_pkg::ROOT_W-1:0] o_root,
    output gcrf_pkg::t_sqrt_stat        o_stat
);
    import gcrf_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [RAD_W-1:0]  r_rad;
    logic [ROOT_W-1:0] r_root;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] n_root;
    logic [REM_W-1:0]  n_rem;
    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;

    // one result bit per step: bring down two radicand bits, try 4*root+1
    always_comb begin
        rem_sh = {r_rem, r_rad[RAD_W-1 -: 2]};
        trial  = {1'b0, r_root, 2'b01};
        if (rem_sh >= trial) begin
            n_rem  = REM_W'(rem_sh - trial);
            n_root = {r_root[ROOT_W-2:0], 1'b1};
        end else begin
            n_rem  = REM_W'(rem_sh);
            n_root = {r_root[ROOT_W-2:0], 1'b0};
        end
    end

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(SQRT_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_root <= '0;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            r_root <= n_root;
            r_rem  <= n_rem;
        end
    end

    assign o_root      = r_root;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

### hw/rtl/gyro_cadence_rpm_filter_top.sv
// gyro cadence filter: three-axis gyro events in, smoothed cadence in rpm out
// input channel (s_axis): tuser is the event kind (0 sample, 1 failed read),
// tdata carries the raw axis counts and the millisecond timestamp
// output channel (m_axis): tdata is rpm in unsigned Q8.8, tuser the status
// (0 fresh, 1 held, 2 stale zero, 3 disabled); one result per request
// configuration: write enable, register index and data; a write lands at the
// clock edge where the enable is high; writes are to be made only while the
// block is idle, and the block itself does not enforce this
// a sample request runs the square phase of the one shared multiply-accumulate
// unit (three squares), the 16-step square root, the scale phase (one scale
// product) and the blend phase (three blend products), then the finish state
// a sample that seeds the average skips the blend products
// a failed read or a request while disabled goes straight to the finish state
// tready is high only while the sequencer is idle, so a new request is taken
// only after the last one has left the finish state
// the finished result sits in an output register; if the receiver stalls with
// that register full, the sequencer holds its last state until it drains
// reset (synchronous, active low) drops the output valid, restores the register
// defaults and clears the average, its seeded flag and the last sample time
`include "gyro_cadence_rpm_filter_top_macros.svh"

module gyro_cadence_rpm_filter_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // config write port
    input  logic                          i_cfg_we,
    input  logic [gcrf_pkg::CFG_AW-1:0]   i_cfg_addr,
    input  logic [gcrf_pkg::CFG_W-1:0]    i_cfg_wdata,
    // input events
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // tdata: raw_x [15:0], raw_y [31:16], raw_z [47:32], now_ms [79:48]
    input  logic [gcrf_pkg::IN_DW-1:0]    i_s_axis_tdata,
    // tuser: operation [0]
    input  logic [0:0]                    i_s_axis_tuser,
    // results
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // tdata: rpm_q8 [15:0]
    output logic [gcrf_pkg::RPM_W-1:0]    o_m_axis_tdata,
    // tuser: status [1:0]
    output logic [1:0]                    o_m_axis_tuser
);
    import gcrf_pkg::*;

    // configuration
    logic              r_ready;
    logic [CFG_W-1:0]  r_scale;
    logic [CFG_W-1:0]  r_min;
    logic [CFG_W-1:0]  r_alpha;
    logic [CFG_W-1:0]  r_timeout;

    // filter state
    logic [FILT_W-1:0] r_filt;
    logic              r_fvalid;
    logic [TIME_W-1:0] r_last;

    // request in progress
    t_state            r_state;
    t_state            n_state;
    logic [1:0]        r_cnt;
    logic [1:0]        n_cnt;
    t_kind             r_kind;
    logic [RAW_W-1:0]  r_x;
    logic [RAW_W-1:0]  r_y;
    logic [RAW_W-1:0]  r_z;
    logic [TIME_W-1:0] r_now;
    logic [RPM_W-1:0]  r_rpm;
    logic              r_seed;

    // output register
    logic              r_out_valid;
    logic [RPM_W-1:0]  r_out_rpm;
    t_status           r_out_status;

    logic              s_accept;
    logic              fin_take;
    t_mac_ctl          mac_ctl;
    logic [MAC_W-1:0]  mac_a;
    logic [MAC_W-1:0]  mac_b;
    logic [ACC_W-1:0]  mac_acc;
    logic              sq_start;
    logic [ROOT_W-1:0] sq_root;
    t_sqrt_stat        sq_stat;
    logic [RPM_W-1:0]  scaled;
    logic [RPM_W-1:0]  rpm_c;
    logic [MAC_W-1:0]  w_old;
    logic [FILT_W-1:0] blend_f;
    logic [TIME_W-1:0] age;
    logic              fresh_ok;
    logic [RPM_W-1:0]  fin_rpm;
    t_status           fin_status;

    assign s_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign fin_take = (r_state == S_FINISH) && (!r_out_valid || i_m_axis_tready);

    // shared multiply-accumulate unit
    gcrf_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_a     (mac_a),
        .i_b     (mac_b),
        .o_acc   (mac_acc)
    );

    // square root of the sum of squares
    gcrf_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_rad   (mac_acc[RAD_W-1:0]),
        .o_root  (sq_root),
        .o_stat  (sq_stat)
    );

    // scaled rpm with the low cut
    assign scaled = mac_acc[2*CFG_W-1:CFG_W];
    assign rpm_c  = (scaled < r_min) ? '0 : scaled;
    assign w_old  = MAC_W'(1 << CFG_W) - {1'b0, r_alpha};

    // finish values
    always_comb begin
        blend_f  = r_seed ? {r_rpm, 8'b0} : mac_acc[FILT_W+CFG_W-1:CFG_W];
        age      = r_now - r_last;
        fresh_ok = r_fvalid && (age[TIME_W-1:CFG_W] == '0)
                   && (age[CFG_W-1:0] <= r_timeout);
        fin_rpm    = '0;
        fin_status = ST_OFF;
        unique case (r_kind)
            K_SAMPLE: begin
                fin_rpm    = blend_f[FILT_W-1:8];
                fin_status = ST_FRESH;
            end
            K_FAIL: begin
                if (fresh_ok) begin
                    fin_rpm    = r_filt[FILT_W-1:8];
                    fin_status = ST_HELD;
                end else begin
                    fin_status = ST_STALE;
                end
            end
            default: begin
                fin_status = ST_OFF;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // sequencer: next state and unit issues
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        mac_ctl  = '0;
        mac_a    = '0;
        mac_b    = '0;
        sq_start = 1'b0;
        o_s_axis_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
                n_cnt = '0;
                if (i_s_axis_tvalid) begin
                    if (r_ready && !i_s_axis_tuser[0]) begin
                        n_state = S_SQUARE;
                    end else begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_SQUARE: begin
                mac_ctl.en  = (r_cnt != 2'd3);
                mac_ctl.clr = (r_cnt == 2'd0);
                unique case (r_cnt)
                    2'd0: begin
                        mac_a = abs17(r_x);
                        mac_b = abs17(r_x);
                    end
                    2'd1: begin
                        mac_a = abs17(r_y);
                        mac_b = abs17(r_y);
                    end
                    default: begin
                        mac_a = abs17(r_z);
                        mac_b = abs17(r_z);
                    end
                endcase
                n_cnt = r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    n_state = S_ROOT;
                end
            end
            S_ROOT: begin
                if (r_cnt == 2'd0) begin
                    sq_start = 1'b1;
                    n_cnt    = 2'd1;
                end else if (sq_stat.done) begin
                    n_state = S_SCALE;
                    n_cnt   = '0;
                end
            end
            S_SCALE: begin
                mac_ctl.en  = (r_cnt == 2'd0);
                mac_ctl.clr = 1'b1;
                mac_a = {1'b0, sq_root};
                mac_b = {1'b0, r_scale};
                n_cnt = r_cnt + 2'd1;
                if (r_cnt == 2'd1) begin
                    n_state = S_BLEND;
                    n_cnt   = '0;
                end
            end
            S_BLEND: begin
                n_cnt = r_cnt + 2'd1;
                unique case (r_cnt)
                    2'd0: begin
                        mac_ctl.en   = r_fvalid;
                        mac_ctl.clr  = 1'b1;
                        mac_ctl.rnd  = 1'b1;
                        mac_ctl.shl8 = 1'b1;
                        mac_a = {1'b0, r_alpha};
                        mac_b = {1'b0, rpm_c};
                        if (!r_fvalid) begin
                            n_state = S_FINISH;
                        end
                    end
                    2'd1: begin
                        mac_ctl.en   = 1'b1;
                        mac_ctl.shl8 = 1'b1;
                        mac_a = w_old;
                        mac_b = {1'b0, r_filt[FILT_W-1:8]};
                    end
                    2'd2: begin
                        mac_ctl.en = 1'b1;
                        mac_a = w_old;
                        mac_b = {9'b0, r_filt[7:0]};
                    end
                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_FINISH: begin
                if (fin_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_x   <= i_s_axis_tdata[RAW_W-1:0];
            r_y   <= i_s_axis_tdata[2*RAW_W-1:RAW_W];
            r_z   <= i_s_axis_tdata[3*RAW_W-1:2*RAW_W];
            r_now <= i_s_axis_tdata[IN_DW-1:3*RAW_W];
            if (!r_ready) begin
                r_kind <= K_OFF;
            end else if (i_s_axis_tuser[0]) begin
                r_kind <= K_FAIL;
            end else begin
                r_kind <= K_SAMPLE;
            end
        end
        if ((r_state == S_BLEND) && (r_cnt == 2'd0)) begin
            r_rpm  <= rpm_c;
            r_seed <= !r_fvalid;
        end
    end

    // configuration and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready   <= 1'b0;
            r_scale   <= RST_SCALE;
            r_min     <= RST_MIN;
            r_alpha   <= RST_ALPHA;
            r_timeout <= RST_TIMEOUT;
            r_filt    <= '0;
            r_fvalid  <= 1'b0;
            r_last    <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_READY: begin
                        if (!r_ready && i_cfg_wdata[0]) begin
                            r_filt   <= '0;
                            r_fvalid <= 1'b0;
                        end
                        r_ready <= i_cfg_wdata[0];
                    end
                    CFG_SCALE:   r_scale   <= i_cfg_wdata;
                    CFG_MIN:     r_min     <= i_cfg_wdata;
                    CFG_ALPHA:   r_alpha   <= i_cfg_wdata;
                    CFG_TIMEOUT: r_timeout <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (fin_take) begin
                unique case (r_kind)
                    K_SAMPLE: begin
                        r_filt   <= blend_f;
                        r_fvalid <= 1'b1;
                        r_last   <= r_now;
                    end
                    K_FAIL: begin
                        if (!fresh_ok) begin
                            r_filt   <= '0;
                            r_fvalid <= 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin_take) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_take) begin
            r_out_rpm    <= fin_rpm;
            r_out_status <= fin_status;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_rpm;
    assign o_m_axis_tuser  = r_out_status;

    // checks
    `GCRF_ASSERT_NEXT(a_busy_after_accept, s_accept, !o_s_axis_tready)
    `GCRF_ASSERT_NEXT(a_seeded_after_sample, fin_take && (r_kind == K_SAMPLE), r_fvalid)
    `GCRF_ASSERT_NOW(a_zero_when_stale_or_off,
        r_out_valid && (r_out_status == ST_STALE || r_out_status == ST_OFF), r_out_rpm == '0)
    `GCRF_ASSERT_NOW(a_root_quiet_outside, r_state != S_ROOT, !sq_stat.busy)

endmodule
